// ----- rtl/id_allocator_with_recycle_queue_macros.svh -----
// Assertion macros shared by the identifier allocator modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ID_ALLOCATOR_WITH_RECYCLE_QUEUE_MACROS_SVH
`define ID_ALLOCATOR_WITH_RECYCLE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property violated");

`endif

// ----- rtl/idalloc_pkg.sv -----
// Types and constants of the identifier allocator.
// Used by the controller, the datapath and the top level.
package idalloc_pkg;

    localparam int ID_W      = 8;
    localparam int NUM_IDS   = 1 << ID_W;
    localparam int ID_MAX    = NUM_IDS - 1;
    localparam int FILL_W    = ID_W + 1;
    localparam int STATUS_W  = 2;
    localparam int WRAP_DEFAULT = 255;

    localparam logic [ID_W-1:0] FRESH_FIRST = ID_W'(1);

    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_RELEASE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] release_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]     result_id;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

endpackage

// ----- rtl/idalloc_ctrl.sv -----
// Controller of the identifier allocator: two-state sequencer.
// Depends on idalloc_pkg and the assertion macro header.
`include "id_allocator_with_recycle_queue_macros.svh"

module idalloc_ctrl
    import idalloc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == S_EXEC);

    `ASSERT_NXT(a_exec_one_cycle, i_clk, i_rst_n, r_state == S_EXEC, r_state == S_IDLE)
    `ASSERT_NXT(a_load_to_exec, i_clk, i_rst_n, o_cmd.load, o_cmd.exec)
    `ASSERT_IMP(a_cmd_exclusive, i_clk, i_rst_n, o_cmd.exec, !o_cmd.load)

endmodule

// ----- rtl/idalloc_dpath.sv -----
// Datapath of the identifier allocator: in-use bitmap, recycle queue memory,
// fresh counter and result register. Depends on idalloc_pkg and the macro header.
`include "id_allocator_with_recycle_queue_macros.svh"

module idalloc_dpath
    import idalloc_pkg::*;
#(
    parameter int WRAP_VALUE = WRAP_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req      i_req,
    input  t_ctrl_cmd i_cmd,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam int LAST_CAP = (WRAP_VALUE - 1 < ID_MAX) ? WRAP_VALUE - 1 : ID_MAX;
    localparam logic [ID_W-1:0] LAST_FRESH = ID_W'(LAST_CAP);

    t_req               r_req;
    logic [NUM_IDS-1:0] r_in_use;
    logic [ID_W-1:0]    r_head;
    logic [ID_W-1:0]    r_tail;
    logic [FILL_W-1:0]  r_fill;
    logic [ID_W-1:0]    r_next_fresh;
    logic               r_fresh_spent;
    logic [ID_W-1:0]    r_q_rdata;
    logic               r_valid;
    t_rsp               r_rsp;
    logic [ID_W-1:0]    r_queue [NUM_IDS];

    logic [ID_W-1:0]    n_head;
    logic [ID_W-1:0]    n_tail;
    logic [FILL_W-1:0]  n_fill;
    logic [ID_W-1:0]    n_next_fresh;
    logic               n_fresh_spent;
    t_rsp               n_rsp;
    logic               w_bit;
    logic               w_bit_we;
    logic               w_bit_val;
    logic [ID_W-1:0]    w_bit_addr;
    logic               w_q_we;

    assign w_bit = r_in_use[r_req.release_id];

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_next_fresh  = r_next_fresh;
        n_fresh_spent = r_fresh_spent;
        n_rsp         = '0;
        w_bit_we      = 1'b0;
        w_bit_val     = 1'b0;
        w_bit_addr    = r_req.release_id;
        w_q_we        = 1'b0;
        case (r_req.command)
            CMD_ALLOCATE: begin
                if (r_fill != '0) begin
                    n_rsp.result_id = r_q_rdata;
                    n_rsp.status    = ST_ALLOCATED;
                    n_head          = r_head + ID_W'(1);
                    n_fill          = r_fill - FILL_W'(1);
                    w_bit_we        = 1'b1;
                    w_bit_val       = 1'b1;
                    w_bit_addr      = r_q_rdata;
                end else if (!r_fresh_spent) begin
                    n_rsp.result_id = r_next_fresh;
                    n_rsp.status    = ST_ALLOCATED;
                    w_bit_we        = 1'b1;
                    w_bit_val       = 1'b1;
                    w_bit_addr      = r_next_fresh;
                    if (r_next_fresh == LAST_FRESH) begin
                        n_fresh_spent = 1'b1;
                        n_next_fresh  = FRESH_FIRST;
                    end else begin
                        n_next_fresh  = r_next_fresh + ID_W'(1);
                    end
                end else begin
                    n_rsp.result_id = '0;
                    n_rsp.status    = ST_EXHAUSTED;
                end
            end
            CMD_RELEASE: begin
                n_rsp.result_id = r_req.release_id;
                if (w_bit) begin
                    n_rsp.status = ST_RELEASED;
                    w_bit_we     = 1'b1;
                    if (r_fill < FILL_W'(NUM_IDS)) begin
                        w_q_we = 1'b1;
                        n_tail = r_tail + ID_W'(1);
                        n_fill = r_fill + FILL_W'(1);
                    end
                end else begin
                    n_rsp.status = ST_IGNORED;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_q_we) begin
            r_queue[r_tail] <= r_req.release_id;
        end
        r_q_rdata <= r_queue[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use      <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_next_fresh  <= FRESH_FIRST;
            r_fresh_spent <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                if (w_bit_we) begin
                    r_in_use[w_bit_addr] <= w_bit_val;
                end
                r_head        <= n_head;
                r_tail        <= n_tail;
                r_fill        <= n_fill;
                r_next_fresh  <= n_next_fresh;
                r_fresh_spent <= n_fresh_spent;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(ID_MAX))
    `ASSERT_IMP(a_queue_ptrs, i_clk, i_rst_n, 1'b1, ID_W'(r_tail - r_head) == r_fill[ID_W-1:0])
    `ASSERT_IMP(a_alloc_marked, i_clk, i_rst_n, o_valid && (o_rsp.status == ST_ALLOCATED), r_in_use[o_rsp.result_id] && (o_rsp.result_id != '0))
    `ASSERT_NXT(a_exec_strobe, i_clk, i_rst_n, i_cmd.exec, o_valid)

endmodule

// ----- rtl/id_allocator_with_recycle_queue.sv -----
// Identifier allocator with recycle queue: top level.
// Instantiates idalloc_ctrl and idalloc_dpath; types from idalloc_pkg.
//
// Usage:
//   Request channel: drive i_req (command, release_id) and raise start; the
//   request is taken at a rising edge where start is high and busy is low.
//   Command allocate hands out the oldest recycled identifier, else a fresh
//   one counting up from 1 to WRAP_VALUE - 1 (at most 255); once the fresh
//   range is used and no identifier waits, the answer is exhausted with id 0.
//   Command release frees an in-use identifier and queues it for reuse; a
//   release of an identifier not in use is answered as ignored.
//   Result channel: o_rsp is valid for exactly one cycle while o_valid is high.
//   Result path: the request is registered, runs in the execute cycle and is
//   then shown from the result register; no request is taken meanwhile, as
//   execute does the read-modify-write of the in-use bitmap and recycle queue.
//   busy is high in the execute cycle only; the next request may be taken at
//   the edge that ends the cycle in which the previous result is shown.
//   Reset (synchronous, active low) clears the bitmap, the queue pointers and
//   the fill count and restarts the fresh counter at 1; no clearing pass.
//   The receiver has no back pressure: results must be taken when shown.
module id_allocator_with_recycle_queue
    import idalloc_pkg::*;
#(
    parameter int WRAP_VALUE = WRAP_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_ctrl_cmd w_cmd;

    idalloc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    idalloc_dpath #(
        .WRAP_VALUE (WRAP_VALUE)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- bench/id_allocator_with_recycle_queue_check.sv -----
// Checker for the identifier allocator: watches the request and result channels,
// predicts each answer and compares it field by field. Types from idalloc_pkg.
module id_allocator_with_recycle_queue_check
    import idalloc_pkg::*;
#(
    parameter int WRAP_VALUE = WRAP_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_valid,
    input  t_rsp i_rsp,
    output int   o_mismatch_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [NUM_IDS-1:0] id_taken;
    logic [ID_W-1:0]    recycled_ids[$];
    logic [ID_W-1:0]    fresh_next;
    logic               fresh_done;
    t_rsp               pending_answers[$];
    int                 mismatch_count = 0;

    task automatic report(input string line);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, line);
    endtask

    function automatic t_rsp answer_request(input t_req r);
        t_rsp a;
        int   after_id;
        a.result_id = '0;
        a.status = ST_EXHAUSTED;
        if (r.command == CMD_ALLOCATE) begin
            if (recycled_ids.size() != 0) begin
                a.result_id = recycled_ids.pop_front();
                a.status = ST_ALLOCATED;
                id_taken[a.result_id] = 1'b1;
            end else if (!fresh_done) begin
                a.result_id = fresh_next;
                a.status = ST_ALLOCATED;
                id_taken[fresh_next] = 1'b1;
                after_id = int'(fresh_next) + 1;
                if (after_id >= WRAP_VALUE || after_id > ID_MAX) begin
                    fresh_done = 1'b1;
                    fresh_next = FRESH_FIRST;
                end else begin
                    fresh_next = ID_W'(after_id);
                end
            end
        end else begin
            a.result_id = r.release_id;
            if (id_taken[r.release_id]) begin
                id_taken[r.release_id] = 1'b0;
                if (recycled_ids.size() < NUM_IDS) begin
                    recycled_ids.push_back(r.release_id);
                end
                a.status = ST_RELEASED;
            end else begin
                a.status = ST_IGNORED;
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            id_taken = '0;
            recycled_ids.delete();
            fresh_next = FRESH_FIRST;
            fresh_done = 1'b0;
            pending_answers.delete();
        end else begin
            if (i_valid) begin
                if (pending_answers.size() == 0) begin
                    report($sformatf("result id %0d status %0d with no request waiting",
                                     i_rsp.result_id, i_rsp.status));
                end else begin
                    want = pending_answers.pop_front();
                    if (i_rsp.result_id !== want.result_id) begin
                        report($sformatf("result_id got %0d want %0d",
                                         i_rsp.result_id, want.result_id));
                    end
                    if (i_rsp.status !== want.status) begin
                        report($sformatf("status got %0d want %0d for id %0d",
                                         i_rsp.status, want.status, want.result_id));
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_answers.push_back(answer_request(i_req));
            end
        end
        o_pending <= pending_answers.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

// ----- bench/id_allocator_with_recycle_queue_test.sv -----
// Top of the identifier allocator bench: clock, reset, request stimulus and verdict.
// Instantiates id_allocator_with_recycle_queue and id_allocator_with_recycle_queue_check.
module id_allocator_with_recycle_queue_test
    import idalloc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_req            i_req = '0;
    logic            o_valid;
    t_rsp            o_rsp;
    int              mismatch_count;
    int              pending_count;
    logic [ID_W-1:0] held_ids[$];
    int              sender_idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    id_allocator_with_recycle_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    id_allocator_with_recycle_queue_check answer_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_req            (i_req),
        .i_valid          (o_valid),
        .i_rsp            (o_rsp),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_count)
    );

    // Advance to the next rising clock edge; collect granted ids for later release.
    task automatic tick();
        @(posedge i_clk);
        if (i_rst_n && o_valid && o_rsp.status == ST_ALLOCATED) begin
            held_ids.push_back(o_rsp.result_id);
        end
    endtask

    task automatic send_request(input logic cmd, input logic [ID_W-1:0] id);
        i_req <= '{command: cmd, release_id: id};
        start <= 1'b1;
        do tick(); while (busy);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) tick();
        end
    endtask

    // Hold requests until every answer is back.
    task automatic drain();
        start <= 1'b0;
        do tick(); while (pending_count != 0);
    endtask

    task automatic release_one(input int held_pct);
        int              k;
        logic [ID_W-1:0] id;
        if (held_ids.size() != 0 && $urandom_range(99) < held_pct) begin
            k = $urandom_range(held_ids.size() - 1);
            id = held_ids[k];
            held_ids.delete(k);
        end else begin
            id = ID_W'($urandom_range(ID_MAX));
        end
        send_request(CMD_RELEASE, id);
    endtask

    task automatic run_mix(input int count, input int idle_pct, input int alloc_pct,
                           input int held_pct);
        sender_idle_pct = idle_pct;
        repeat (count) begin
            if ($urandom_range(99) < alloc_pct) begin
                send_request(CMD_ALLOCATE, ID_W'($urandom_range(ID_MAX)));
            end else begin
                release_one(held_pct);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tick();

        sender_idle_pct = 30;
        send_request(CMD_RELEASE, 8'd0);
        send_request(CMD_RELEASE, 8'd255);
        send_request(CMD_RELEASE, 8'd1);
        send_request(CMD_ALLOCATE, 8'd0);
        send_request(CMD_ALLOCATE, 8'd255);
        send_request(CMD_ALLOCATE, 8'd170);
        send_request(CMD_RELEASE, 8'd2);
        send_request(CMD_RELEASE, 8'd2);
        send_request(CMD_ALLOCATE, 8'd85);
        send_request(CMD_ALLOCATE, 8'd0);
        send_request(CMD_RELEASE, 8'd1);
        send_request(CMD_RELEASE, 8'd3);
        send_request(CMD_ALLOCATE, 8'd0);
        send_request(CMD_ALLOCATE, 8'd0);
        send_request(CMD_ALLOCATE, 8'd0);
        send_request(CMD_RELEASE, 8'd128);
        send_request(CMD_RELEASE, 8'd5);
        send_request(CMD_RELEASE, 8'd4);
        send_request(CMD_ALLOCATE, 8'd0);
        send_request(CMD_RELEASE, 8'd170);
        send_request(CMD_RELEASE, 8'd85);
        drain();
        held_ids.delete();
        for (int i = 1; i <= 5; i++) begin
            if (i != 4) held_ids.push_back(ID_W'(i));
        end

        run_mix(650, 30, 55, 75);
        drain();
        run_mix(650, 56, 85, 80);
        drain();

        sender_idle_pct = 0;
        while (held_ids.size() != 0) release_one(100);
        run_mix(420, 0, 50, 70);

        drain();
        repeat (4) tick();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
